>>> src/fvn_pkg.sv
// shared constants for the fractal value noise pipeline
// hash constants, coordinate width, register indexes and the normalizing reciprocal table
// no dependencies
package fvn_pkg;

   localparam int COORD_BITS        = 28;
   localparam int DEF_MAX_OCTAVES   = 8;
   localparam int DEF_FRACTION_BITS = 16;

   localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
   localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
   localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
   localparam logic [31:0] SEED_STEP    = 32'd7919;

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 32;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEED    = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OCTAVES = 4'd1;

   localparam int RECIP_BITS = 31;

   // round(2^(29+n) / (2^n - 1)), a Q1.30 reciprocal of the total amplitude
   function automatic logic [RECIP_BITS-1:0] recip_of(input logic [4:0] n);
      logic [RECIP_BITS-1:0] r;
      case (n)
         5'd1:    r = 31'd1073741824;
         5'd2:    r = 31'd715827883;
         5'd3:    r = 31'd613566757;
         5'd4:    r = 31'd572662306;
         5'd5:    r = 31'd554189329;
         5'd6:    r = 31'd545392673;
         5'd7:    r = 31'd541098242;
         5'd8:    r = 31'd538976288;
         5'd9:    r = 31'd537921540;
         5'd10:   r = 31'd537395713;
         5'd11:   r = 31'd537133184;
         5'd12:   r = 31'd537002016;
         5'd13:   r = 31'd536936456;
         5'd14:   r = 31'd536903682;
         5'd15:   r = 31'd536887297;
         5'd16:   r = 31'd536879104;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> src/fvn_octave.sv
// one octave of value noise as a seven stage pipeline: lattice split, hash, smoothstep, lerp
// depends on fvn_pkg; all stages advance together on the shared enable
module fvn_octave #(
   parameter int OCTAVE        = 0,
   parameter int MAX_OCTAVES   = fvn_pkg::DEF_MAX_OCTAVES,
   parameter int FRACTION_BITS = fvn_pkg::DEF_FRACTION_BITS
) (
   input  logic                                    clock,
   input  logic                                    en,
   input  logic signed [fvn_pkg::COORD_BITS-1:0]   x_coord,
   input  logic signed [fvn_pkg::COORD_BITS-1:0]   y_coord,
   input  logic [31:0]                             seed,
   output logic signed [FRACTION_BITS+1:0]         contrib
);
   import fvn_pkg::*;

   localparam int F  = FRACTION_BITS;
   localparam int XW = COORD_BITS + MAX_OCTAVES + 32;
   localparam logic [31:0] SEED_OFS = 32'(OCTAVE) * SEED_STEP;
   localparam logic [F+1:0] THREE_ONE = (F+2)'(3) << F;
   localparam logic signed [F+1:0] ONE = (F+2)'(1) << F;

   // stage a
   logic signed [XW-1:0] xs, ys;
   logic [31:0] x0_ff, y0_ff, seeda_ff;
   logic [F-1:0] txa_ff, tya_ff;

   assign xs = XW'(x_coord) <<< OCTAVE;
   assign ys = XW'(y_coord) <<< OCTAVE;

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff    <= xs[F +: 32];
         y0_ff    <= ys[F +: 32];
         txa_ff   <= xs[F-1:0];
         tya_ff   <= ys[F-1:0];
         seeda_ff <= seed + SEED_OFS;
      end
   end

   // stage b: corner products and t squared
   logic [31:0] px0_in, px1_in, py0_in, py1_in;
   logic [31:0] px0_ff, px1_ff, py0_ff, py1_ff, seedb_ff;
   logic [2*F-1:0] ttx, tty;
   logic [F-1:0] t2x_ff, t2y_ff, txb_ff, tyb_ff;

   assign px0_in = 32'(x0_ff * HASH_MUL_X);
   assign px1_in = 32'((x0_ff + 32'd1) * HASH_MUL_X);
   assign py0_in = 32'(y0_ff * HASH_MUL_Y);
   assign py1_in = 32'((y0_ff + 32'd1) * HASH_MUL_Y);
   assign ttx = txa_ff * txa_ff;
   assign tty = tya_ff * tya_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         px0_ff   <= px0_in;
         px1_ff   <= px1_in;
         py0_ff   <= py0_in;
         py1_ff   <= py1_in;
         seedb_ff <= seeda_ff;
         t2x_ff   <= ttx[2*F-1:F];
         t2y_ff   <= tty[2*F-1:F];
         txb_ff   <= txa_ff;
         tyb_ff   <= tya_ff;
      end
   end

   // stage c: xor fold and smoothstep weight
   logic [31:0] h00, h10, h01, h11;
   logic [31:0] g00_ff, g10_ff, g01_ff, g11_ff;
   logic [F+1:0] kx, ky;
   logic [2*F+1:0] swx, swy;
   logic [F:0] sxc_ff, syc_ff;

   assign h00 = seedb_ff ^ px0_ff ^ py0_ff;
   assign h10 = seedb_ff ^ px1_ff ^ py0_ff;
   assign h01 = seedb_ff ^ px0_ff ^ py1_ff;
   assign h11 = seedb_ff ^ px1_ff ^ py1_ff;
   assign kx  = THREE_ONE - {1'b0, txb_ff, 1'b0};
   assign ky  = THREE_ONE - {1'b0, tyb_ff, 1'b0};
   assign swx = t2x_ff * kx;
   assign swy = t2y_ff * ky;

   always_ff @(posedge clock) begin
      if (en) begin
         g00_ff <= h00 ^ (h00 >> 13);
         g10_ff <= h10 ^ (h10 >> 13);
         g01_ff <= h01 ^ (h01 >> 13);
         g11_ff <= h11 ^ (h11 >> 13);
         sxc_ff <= swx[2*F:F];
         syc_ff <= swy[2*F:F];
      end
   end

   // stage d: mixing multiply
   logic [31:0] m00_ff, m10_ff, m01_ff, m11_ff;
   logic [F:0] sxd_ff, syd_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         m00_ff <= 32'(g00_ff * HASH_MUL_MIX);
         m10_ff <= 32'(g10_ff * HASH_MUL_MIX);
         m01_ff <= 32'(g01_ff * HASH_MUL_MIX);
         m11_ff <= 32'(g11_ff * HASH_MUL_MIX);
         sxd_ff <= sxc_ff;
         syd_ff <= syc_ff;
      end
   end

   // stage e: corner values in [-1,1)
   logic [31:0] q00, q10, q01, q11;
   logic signed [F+1:0] n00_ff, n10_ff, n01_ff, n11_ff;
   logic [F:0] sxe_ff, sye_ff;

   assign q00 = m00_ff ^ (m00_ff >> 16);
   assign q10 = m10_ff ^ (m10_ff >> 16);
   assign q01 = m01_ff ^ (m01_ff >> 16);
   assign q11 = m11_ff ^ (m11_ff >> 16);

   always_ff @(posedge clock) begin
      if (en) begin
         n00_ff <= $signed({1'b0, q00[31:31-F]}) - ONE;
         n10_ff <= $signed({1'b0, q10[31:31-F]}) - ONE;
         n01_ff <= $signed({1'b0, q01[31:31-F]}) - ONE;
         n11_ff <= $signed({1'b0, q11[31:31-F]}) - ONE;
         sxe_ff <= sxd_ff;
         sye_ff <= syd_ff;
      end
   end

   // stage f: lerp along x
   logic signed [F+2:0] da, db;
   logic signed [2*F+4:0] pa, pb;
   logic signed [F+1:0] a_ff, b_ff;
   logic [F:0] syf_ff;

   assign da = (F+3)'(n10_ff) - (F+3)'(n00_ff);
   assign db = (F+3)'(n11_ff) - (F+3)'(n01_ff);
   assign pa = da * $signed({1'b0, sxe_ff});
   assign pb = db * $signed({1'b0, sxe_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff   <= n00_ff + (F+2)'(pa >>> F);
         b_ff   <= n01_ff + (F+2)'(pb >>> F);
         syf_ff <= sye_ff;
      end
   end

   // stage g: lerp along y and amplitude scaling
   logic signed [F+2:0] dv;
   logic signed [2*F+4:0] pv;
   logic signed [F+1:0] v;

   assign dv = (F+3)'(b_ff) - (F+3)'(a_ff);
   assign pv = dv * $signed({1'b0, syf_ff});
   assign v  = a_ff + (F+2)'(pv >>> F);

   always_ff @(posedge clock) begin
      if (en) begin
         contrib <= v >>> OCTAVE;
      end
   end

endmodule

>>> src/fractal_value_noise_top.sv
// fractal value noise: parallel octave pipelines, octave sum, reciprocal scaling, clamp
// depends on fvn_pkg and fvn_octave
//
// channel   dir   handshake              payload
// req       in    req_tvalid/req_tready  req_tdata: x_coord, y_coord
// rsp       out   rsp_tvalid/rsp_tready  rsp_tdata: noise_value
// csr       in    csr_valid/csr_ready    csr_index, csr_data
//
// one point enters per cycle while the output is not stalled (7 octave stages, sum, scale, output)
// all octaves run side by side, each in its own lane of hashing multipliers
// reset clears the valid bits and sets seed 0, octave count 3
// a stalled output holds the whole pipeline; bubbles stay in place while it waits
module fractal_value_noise_top #(
   parameter int MAX_OCTAVES   = fvn_pkg::DEF_MAX_OCTAVES,
   parameter int FRACTION_BITS = fvn_pkg::DEF_FRACTION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [2*fvn_pkg::COORD_BITS-1:0]    req_tdata,  // x_coord, y_coord
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [((FRACTION_BITS+9)/8)*8-1:0]  rsp_tdata,  // noise_value
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fvn_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [fvn_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import fvn_pkg::*;

   localparam int F      = FRACTION_BITS;
   localparam int OW     = F + 2;
   localparam int RW     = ((F + 9) / 8) * 8;
   localparam int OCT_D  = 7;
   localparam int DEPTH  = OCT_D + 3;
   localparam int SW     = F + 5;
   localparam int NW     = 5;

   logic [31:0] seed_ff;
   logic [3:0]  octave_count_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff         <= '0;
         octave_count_ff <= 4'd3;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SEED:    seed_ff         <= csr_data;
            CSR_OCTAVES: octave_count_ff <= csr_data[3:0];
            default:     ;
         endcase
      end
   end

   logic [NW-1:0] n_eff;
   assign n_eff = ({1'b0, octave_count_ff} > NW'(MAX_OCTAVES)) ? NW'(MAX_OCTAVES)
                                                             : {1'b0, octave_count_ff};

   logic en;
   logic [DEPTH-1:0] valid_ff;

   assign en         = !valid_ff[DEPTH-1] || rsp_tready;
   assign req_tready = en && !reset;
   assign rsp_tvalid = valid_ff[DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[DEPTH-2:0], req_tvalid};
      end
   end

   logic signed [COORD_BITS-1:0] x_coord, y_coord;
   assign x_coord = req_tdata[COORD_BITS-1:0];
   assign y_coord = req_tdata[2*COORD_BITS-1:COORD_BITS];

   logic signed [OW-1:0] contrib [MAX_OCTAVES];

   for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_oct
      fvn_octave #(
         .OCTAVE(o),
         .MAX_OCTAVES(MAX_OCTAVES),
         .FRACTION_BITS(FRACTION_BITS)
      ) u_oct (
         .clock(clock),
         .en(en),
         .x_coord(x_coord),
         .y_coord(y_coord),
         .seed(seed_ff),
         .contrib(contrib[o])
      );
   end

   // octave sum
   logic signed [SW-1:0] sum_in, sum_ff;
   always_comb begin
      sum_in = '0;
      for (int o = 0; o < MAX_OCTAVES; o++) begin
         if (NW'(o) < n_eff) sum_in = sum_in + SW'(contrib[o]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) sum_ff <= sum_in;
   end

   // scale by the amplitude reciprocal
   logic signed [63:0] prod_ff;
   always_ff @(posedge clock) begin
      if (en) prod_ff <= 64'(sum_ff) * 64'($signed({1'b0, recip_of(n_eff)}));
   end

   // round, clamp, output register
   logic signed [63:0] rnd;
   logic signed [OW-1:0] res_in, res_ff;
   localparam logic signed [63:0] LIM = 64'sd1 <<< F;

   assign rnd = (prod_ff + (64'sd1 <<< 29)) >>> 30;

   always_comb begin
      if (n_eff == '0)       res_in = '0;
      else if (rnd > LIM)    res_in = OW'(LIM);
      else if (rnd < -LIM)   res_in = OW'(-LIM);
      else                   res_in = OW'(rnd);
   end

   always_ff @(posedge clock) begin
      if (en) res_ff <= res_in;
   end

   assign rsp_tdata = RW'({{(RW-OW){1'b0}}, res_ff});

endmodule

>>> test/tb_top.sv
// self-checking testbench for fractal_value_noise_top: directed table, then random points
// over several seed/octave settings, with bursty input, stalling output and a bit-exact predictor
// depends on fvn_pkg and the fractal_value_noise_top rtl
`timescale 1ns / 100ps

module tb_top;
   import fvn_pkg::*;

   localparam int OUT_BITS = 18;
   localparam int FB = DEF_FRACTION_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED = 4'd7;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LATENCY = 16;

   typedef struct {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
      bit                           no_octaves;
      bit                           known;
      logic signed [OUT_BITS-1:0]   value;
   } point_row_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [2*COORD_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic csr_valid = 0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   logic [31:0] seed_shadow = 32'd0;
   logic [3:0]  octaves_shadow = 4'd3;
   logic signed [OUT_BITS-1:0] expected_noise[$];
   int  mismatches = 0;
   int  cycles = 0;
   bit  hold_request = 0;

   fractal_value_noise_top uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function automatic longint corner_value(logic [31:0] cx, logic [31:0] cy, logic [31:0] s);
      logic [31:0] h;
      h = s ^ (cx * HASH_MUL_X) ^ (cy * HASH_MUL_Y);
      h = (h ^ (h >> 13)) * HASH_MUL_MIX;
      h = h ^ (h >> 16);
      return longint'({32'd0, h >> (31 - FB)}) - (longint'(1) << FB);
   endfunction

   function automatic longint smooth_weight(longint t);
      longint t2;
      longint k;
      t2 = (t * t) >> FB;
      k = (longint'(3) << FB) - 2 * t;
      return (t2 * k) >> FB;
   endfunction

   function automatic longint blend(longint a, longint b, longint w);
      return a + (((b - a) * w) >>> FB);
   endfunction

   function automatic longint octave_noise(longint xs, longint ys, logic [31:0] s);
      longint xi, yi, sx, sy, a, b;
      logic [31:0] x0, y0;
      xi = xs >>> FB;
      yi = ys >>> FB;
      sx = smooth_weight(xs & ((longint'(1) << FB) - 1));
      sy = smooth_weight(ys & ((longint'(1) << FB) - 1));
      x0 = xi[31:0];
      y0 = yi[31:0];
      a = blend(corner_value(x0, y0, s), corner_value(x0 + 1, y0, s), sx);
      b = blend(corner_value(x0, y0 + 1, s), corner_value(x0 + 1, y0 + 1, s), sx);
      return blend(a, b, sy);
   endfunction

   function automatic logic signed [OUT_BITS-1:0] noise_at(logic signed [COORD_BITS-1:0] x,
                                                           logic signed [COORD_BITS-1:0] y);
      longint xl, yl, total, den, recip, res, lim;
      int n;
      xl = x;
      yl = y;
      n = octaves_shadow;
      total = 0;
      lim = longint'(1) << FB;
      if (n > DEF_MAX_OCTAVES) n = DEF_MAX_OCTAVES;
      if (n == 0) return '0;
      for (int o = 0; o < n; o++) begin
         total += octave_noise(xl <<< o, yl <<< o, seed_shadow + o * SEED_STEP) >>> o;
      end
      den = (longint'(1) << n) - 1;
      recip = ((longint'(1) << (29 + n)) + den / 2) / den;
      res = (total * recip + (longint'(1) << 29)) >>> 30;
      if (res > lim) res = lim;
      if (res < -lim) res = -lim;
      return res[OUT_BITS-1:0];
   endfunction

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] value);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
      if (idx == CSR_SEED) seed_shadow = value;
      else if (idx == CSR_OCTAVES) octaves_shadow = value[3:0];
   endtask

   task automatic wait_drained();
      while (expected_noise.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // one point transfer, then maybe drop valid for a random gap
   task automatic send_point(point_row_type row);
      req_tvalid <= 1;
      req_tdata <= {row.y, row.x};
      do @(posedge clock); while (!req_tready);
      expected_noise.push_back(row.known ? row.value : noise_at(row.x, row.y));
      if ($urandom_range(0, 3) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   function automatic point_row_type random_point();
      point_row_type r;
      r.no_octaves = 0;
      r.known = 0;
      r.value = '0;
      if ($urandom_range(0, 9) < 7) begin
         r.x = COORD_BITS'($urandom);
         r.y = COORD_BITS'($urandom);
      end else begin
         r.x = COORD_BITS'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
         r.y = COORD_BITS'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
      end
      return r;
   endfunction

   localparam logic signed [COORD_BITS-1:0] CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   point_row_type point_table[] = '{
      '{28'sd0, 28'sd0, 0, 0, 0},
      '{CMAX, CMAX, 0, 0, 0},
      '{CMIN, CMIN, 0, 0, 0},
      '{CMAX, CMIN, 0, 0, 0},
      '{CMIN, CMAX, 0, 0, 0},
      '{28'sd1, 28'sd0, 0, 0, 0},
      '{28'sd65535, 28'sd65535, 0, 0, 0},
      '{28'sd65536, 28'sd32768, 0, 0, 0},
      '{-28'sd1, -28'sd1, 0, 0, 0},
      '{-28'sd65536, 28'sd98304, 0, 0, 0},
      '{28'sd32768, -28'sd32768, 0, 0, 0},
      '{28'sd0, 28'sd0, 1, 1, 18'sd0},
      '{CMAX, CMIN, 1, 1, 18'sd0},
      '{28'sd12345, -28'sd777, 1, 1, 18'sd0},
      '{-28'sd1, 28'sd65535, 1, 1, 18'sd0}
   };

   // receiver: stall pattern is redrawn at random from three modes, plus one long hold-off
   initial begin
      int mode;
      int hold;
      mode = 0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_noise.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected transfer: %0d", $signed(rsp_tdata[17:0]));
            end else begin
               logic signed [OUT_BITS-1:0] want;
               want = expected_noise.pop_front();
               if (rsp_tdata[OUT_BITS-1:0] !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("noise_value mismatch: expected %0d actual %0d",
                              want, $signed(rsp_tdata[17:0]));
               end
            end
         end
         if (hold_request && hold == 0) begin
            hold_request = 0;
            hold = 300;
         end
         if (cycles % 64 == 0) mode = $urandom_range(0, 2);
         if (hold > 0) begin
            hold--;
            rsp_tready <= 0;
         end else if (!reset) begin
            case (mode)
               0: rsp_tready <= 1;
               1: rsp_tready <= $urandom_range(0, 1);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      logic [31:0] seeds[6];
      logic [3:0]  octs[6];
      seeds = '{32'hFFFFFFFF, 32'd0, 32'd12345, 32'hFFFFF000, 32'd1, 32'h0};
      octs  = '{4'd8, 4'd1, 4'd15, 4'd2, 4'd5, 4'd3};
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (point_table[i]) if (!point_table[i].no_octaves) send_point(point_table[i]);
      req_tvalid <= 0;
      wait_drained();
      csr_write(CSR_OCTAVES, 32'd0);
      foreach (point_table[i]) if (point_table[i].no_octaves) send_point(point_table[i]);
      req_tvalid <= 0;
      wait_drained();
      csr_write(CSR_UNUSED, $urandom);
      for (int p = 0; p < 6; p++) begin
         csr_write(CSR_SEED, p == 5 ? $urandom : seeds[p]);
         csr_write(CSR_OCTAVES, {28'd0, octs[p]});
         if (p == 1) hold_request = 1;
         for (int k = 0; k < 85; k++) send_point(random_point());
         req_tvalid <= 0;
         wait_drained();
      end
      if (mismatches == 0 && expected_noise.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> fractal_value_noise_top.f
src/fvn_pkg.sv
src/fvn_octave.sv
src/fractal_value_noise_top.sv
test/tb_top.sv
